### src/mcr_pkg.sv
// shared types and constants of the midpoint circle ring rasteriser
package mcr_pkg;

  // configuration register indexes
  localparam int unsigned CFG_IDX_BITS = 2;
  localparam logic [CFG_IDX_BITS-1:0] CFG_CENTER_X     = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_CENTER_Y     = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_OUTER_RADIUS = 2'd2;
  localparam logic [CFG_IDX_BITS-1:0] CFG_INNER_RADIUS = 2'd3;

  // midpoint increments
  localparam int unsigned DEC_INIT_BASE = 1;
  localparam int unsigned INC_EAST_INIT = 3;
  localparam int unsigned INC_SE_BASE   = 5;
  localparam int unsigned INC_STEP_E    = 2;
  localparam int unsigned INC_STEP_SE   = 4;

  // points emitted per midpoint step
  localparam int unsigned OUTER_POINTS = 8;
  localparam int unsigned RING_POINTS  = 4;
  localparam int unsigned POINT_BITS   = 3;

  // depth of the step queue between front and back
  localparam int unsigned QUEUE_DEPTH = 2;

  localparam int unsigned KIND_BITS = 2;

  typedef enum logic [1:0] {
    PH_OUTER = 2'd0,
    PH_RING  = 2'd1,
    PH_DONE  = 2'd2
  } phase_e;

  typedef enum logic [KIND_BITS-1:0] {
    JOB_DONE  = 2'd0,
    JOB_OUTER = 2'd1,
    JOB_RING  = 2'd2
  } job_kind_e;

endpackage

### src/midpoint_circle_ring_raster_top.sv
// top level of the midpoint circle ring rasteriser
//
//   channel  | handshake                  | payload
//   ---------+----------------------------+---------------------------------------
//   tick in  | in_valid_i / in_stall_o    | restart_i
//   pixel out| out_valid_o / out_stall_i  | pixel_x_o pixel_y_o pixel_valid_o
//            |                            | last_o done_res_o
//   config   | cfg_we_i                   | cfg_idx_i cfg_data_i
//
// a tick is taken whenever the two-entry step queue has room;
// the front end runs the iteration in the same cycle as it takes the tick.
// the back end sends one transaction per cycle while out_stall_i lets it: an outline step gives 8 pixels,
// a ring step 4 and a done result one transaction, so the pixel port sets the sustained rate.
// out_stall_i holds the output register; the queue then fills and raises in_stall_o.
// reset clears the configuration to zero and leaves the raster in its done phase.
module midpoint_circle_ring_raster_top #(
  parameter int unsigned COORD_BITS = 12
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [mcr_pkg::CFG_IDX_BITS-1:0]   cfg_idx_i,
  input  logic [COORD_BITS-1:0]              cfg_data_i,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic                               restart_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic signed [COORD_BITS+1:0]       pixel_x_o,
  output logic signed [COORD_BITS+1:0]       pixel_y_o,
  output logic                               pixel_valid_o,
  output logic                               last_o,
  output logic                               done_res_o
);
  import mcr_pkg::*;

  localparam int unsigned JW = 2 * (COORD_BITS + 1) + KIND_BITS;

  logic [COORD_BITS-1:0] center_x_q, center_y_q, outer_radius_q, inner_radius_q;
  logic                  push, pop, full, empty, back_busy;
  logic [JW-1:0]         job_in, job_out;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      center_x_q     <= '0;
      center_y_q     <= '0;
      outer_radius_q <= '0;
      inner_radius_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_CENTER_X:     center_x_q     <= cfg_data_i;
        CFG_CENTER_Y:     center_y_q     <= cfg_data_i;
        CFG_OUTER_RADIUS: outer_radius_q <= cfg_data_i;
        CFG_INNER_RADIUS: inner_radius_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  mcr_front #(
    .COORD_BITS(COORD_BITS)
  ) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .restart_i      (restart_i),
    .in_stall_o     (in_stall_o),
    .outer_radius_i (outer_radius_q),
    .inner_radius_i (inner_radius_q),
    .full_i         (full),
    .push_o         (push),
    .job_o          (job_in)
  );

  mcr_queue #(
    .WIDTH(JW)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (job_in),
    .full_o  (full),
    .pop_i   (pop),
    .data_o  (job_out),
    .empty_o (empty)
  );

  mcr_back #(
    .COORD_BITS(COORD_BITS)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .center_x_i    (center_x_q),
    .center_y_i    (center_y_q),
    .job_i         (job_out),
    .empty_i       (empty),
    .pop_o         (pop),
    .busy_o        (back_busy),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .pixel_x_o     (pixel_x_o),
    .pixel_y_o     (pixel_y_o),
    .pixel_valid_o (pixel_valid_o),
    .last_o        (last_o),
    .done_res_o    (done_res_o)
  );

  // a full queue means the back end is still expanding a step
  a_full_implies_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> back_busy)
    else $error("step queue full while back end idle");

  a_done_has_no_pixel: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && done_res_o |-> !pixel_valid_o && last_o)
    else $error("done result carries a pixel or is not last");

  a_mid_step_is_pixel: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !last_o |-> pixel_valid_o && !done_res_o)
    else $error("non-final result of a step is not a pixel");

  // the queue never pops while empty
  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> !empty)
    else $error("step queue popped while empty");

endmodule

### src/mcr_front.sv
// front end: accepts ticks, runs one midpoint iteration and queues the step
module mcr_front #(
  parameter int unsigned COORD_BITS = 12
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  input  logic                      restart_i,
  output logic                      in_stall_o,
  input  logic [COORD_BITS-1:0]     outer_radius_i,
  input  logic [COORD_BITS-1:0]     inner_radius_i,
  input  logic                      full_i,
  output logic                      push_o,
  output logic [2*COORD_BITS+3:0]   job_o
);
  import mcr_pkg::*;

  localparam int unsigned SB = COORD_BITS + 1;
  localparam int unsigned DB = COORD_BITS + 4;

  typedef struct packed {
    phase_e        phase;
    logic [SB-1:0] sx;
    logic [SB-1:0] sy;
    logic [SB-1:0] ring;
    logic [DB-1:0] dec;
    logic [DB-1:0] ince;
    logic [DB-1:0] incse;
  } circ_t;

  circ_t     state_q, state_d;
  circ_t     cur, s1, s2;
  logic      drawing;
  job_kind_e kind;

  function automatic circ_t start_circle(circ_t s, logic [SB-1:0] r);
    circ_t         t;
    logic [DB-1:0] rw;
    t       = s;
    rw      = DB'(r);
    t.sx    = '0;
    t.sy    = r;
    t.dec   = DB'(DEC_INIT_BASE) - rw;
    t.ince  = DB'(INC_EAST_INIT);
    t.incse = DB'(INC_SE_BASE) - (rw << 1);
    return t;
  endfunction

  // move to the next circle when the current one has no iteration left
  function automatic circ_t settle(circ_t s, logic [COORD_BITS-1:0] outer,
                                   logic [COORD_BITS-1:0] inner);
    circ_t         t;
    logic [SB-1:0] r;
    t = s;
    r = '0;
    if ((s.phase == PH_OUTER || s.phase == PH_RING) && !(s.sx < s.sy)) begin
      if (s.phase == PH_OUTER) begin
        r       = SB'(inner);
        t.phase = PH_RING;
      end else begin
        r = s.ring + SB'(1);
      end
      t.ring = r;
      if (r < SB'(outer)) begin
        t = start_circle(t, r);
      end else begin
        t.phase = PH_DONE;
      end
    end
    return t;
  endfunction

  function automatic circ_t iterate(circ_t s);
    circ_t t;
    t = s;
    if (s.dec[DB-1]) begin
      t.dec   = s.dec + s.ince;
      t.incse = s.incse + DB'(INC_STEP_E);
    end else begin
      t.dec   = s.dec + s.incse;
      t.incse = s.incse + DB'(INC_STEP_SE);
      t.sy    = s.sy - SB'(1);
    end
    t.ince = s.ince + DB'(INC_STEP_E);
    t.sx   = s.sx + SB'(1);
    return t;
  endfunction

  always_comb begin
    cur = state_q;
    if (restart_i) begin
      cur.phase = PH_OUTER;
      cur.ring  = '0;
      cur       = start_circle(cur, SB'(outer_radius_i));
    end
    // a zero radius circle can be passed over once before drawing resumes
    s1 = settle(cur, outer_radius_i, inner_radius_i);
    s2 = settle(s1, outer_radius_i, inner_radius_i);
    drawing = (s2.phase == PH_OUTER || s2.phase == PH_RING) && (s2.sx < s2.sy);
    if (!drawing) begin
      kind = JOB_DONE;
    end else if (s2.phase == PH_OUTER) begin
      kind = JOB_OUTER;
    end else begin
      kind = JOB_RING;
    end
    state_d = drawing ? iterate(s2) : s2;
  end

  assign in_stall_o = full_i;
  assign push_o     = in_valid_i && !full_i;
  assign job_o      = {kind, s2.sx, s2.sy};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.phase <= PH_DONE;
      state_q.sx    <= '0;
      state_q.sy    <= '0;
      state_q.ring  <= '0;
      state_q.dec   <= '0;
      state_q.ince  <= DB'(INC_EAST_INIT);
      state_q.incse <= '0;
    end else if (push_o) begin
      state_q <= state_d;
    end
  end

endmodule

### src/mcr_queue.sv
// short step queue between the front end and the pixel back end
module mcr_queue #(
  parameter int unsigned WIDTH = 28
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] data_o,
  output logic             empty_o
);
  import mcr_pkg::*;

  localparam int unsigned PTR_BITS = $clog2(QUEUE_DEPTH);
  localparam int unsigned CNT_BITS = $clog2(QUEUE_DEPTH + 1);

  logic [WIDTH-1:0]    mem_q [QUEUE_DEPTH];
  logic [PTR_BITS-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CNT_BITS-1:0] count_q, count_d;

  assign full_o  = (count_q == CNT_BITS'(QUEUE_DEPTH));
  assign empty_o = (count_q == '0);
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

### src/mcr_back.sv
// back end: expands one queued step into its symmetric pixels, one per cycle unless the output is stalled
module mcr_back #(
  parameter int unsigned COORD_BITS = 12
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [COORD_BITS-1:0]         center_x_i,
  input  logic [COORD_BITS-1:0]         center_y_i,
  input  logic [2*COORD_BITS+3:0]       job_i,
  input  logic                          empty_i,
  output logic                          pop_o,
  output logic                          busy_o,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic signed [COORD_BITS+1:0]  pixel_x_o,
  output logic signed [COORD_BITS+1:0]  pixel_y_o,
  output logic                          pixel_valid_o,
  output logic                          last_o,
  output logic                          done_res_o
);
  import mcr_pkg::*;

  localparam int unsigned SB = COORD_BITS + 1;
  localparam int unsigned PB = COORD_BITS + 2;
  localparam int unsigned JW = 2 * SB + KIND_BITS;

  logic                  busy_q, busy_d;
  job_kind_e             kind_q;
  logic [SB-1:0]         jx_q, jy_q;
  logic [POINT_BITS-1:0] idx_q, idx_d;
  logic [POINT_BITS-1:0] sel;
  logic [SB-1:0]         a, b;
  logic [PB-1:0]         cxw, cyw, aw, bw, px, py;
  logic                  is_last, fire;
  logic                  out_valid_q;

  always_comb begin
    // ring steps use the second-quadrant and fourth-quadrant points only
    sel = (kind_q == JOB_RING) ? {idx_q[1], 1'b1, idx_q[0]} : idx_q;
    a   = sel[0] ? jy_q : jx_q;
    b   = sel[0] ? jx_q : jy_q;
    cxw = PB'(center_x_i);
    cyw = PB'(center_y_i);
    aw  = PB'(a);
    bw  = PB'(b);
    px  = (sel[2] ^ sel[1]) ? cxw - aw : cxw + aw;
    py  = sel[2] ? cyw + bw : cyw - bw;
    case (kind_q)
      JOB_OUTER: is_last = (idx_q == POINT_BITS'(OUTER_POINTS - 1));
      JOB_RING:  is_last = (idx_q == POINT_BITS'(RING_POINTS - 1));
      default:   is_last = 1'b1;
    endcase
  end

  assign fire   = busy_q && (!out_valid_q || !out_stall_i);
  assign pop_o  = !empty_i && (!busy_q || (fire && is_last));
  assign busy_o = busy_q;
  assign out_valid_o = out_valid_q;

  always_comb begin
    busy_d = busy_q;
    idx_d  = idx_q;
    if (pop_o) begin
      busy_d = 1'b1;
      idx_d  = '0;
    end else if (fire && is_last) begin
      busy_d = 1'b0;
    end else if (fire) begin
      idx_d = idx_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      idx_q  <= idx_d;
      if (fire) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      kind_q <= job_kind_e'(job_i[JW-1 -: KIND_BITS]);
      jx_q   <= job_i[2*SB-1 -: SB];
      jy_q   <= job_i[SB-1:0];
    end
    if (fire) begin
      if (kind_q == JOB_OUTER || kind_q == JOB_RING) begin
        pixel_x_o     <= px;
        pixel_y_o     <= py;
        pixel_valid_o <= 1'b1;
        last_o        <= is_last;
        done_res_o    <= 1'b0;
      end else begin
        pixel_x_o     <= '0;
        pixel_y_o     <= '0;
        pixel_valid_o <= 1'b0;
        last_o        <= 1'b1;
        done_res_o    <= 1'b1;
      end
    end
  end

endmodule
